// ===== hdl/pfx_pkg.sv =====
// Shared types and constants for the postfix expression evaluator.
// Beat payload structs, error codes, symbol codes, controller states, command/status bundles.
// No dependencies.
package pfx_pkg;

    typedef struct packed {
        logic [7:0]         symbol;
        logic signed [31:0] operand_value;
        logic               end_of_expression;
    } pfx_in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
    } pfx_out_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2,
        ERR_DIVZERO   = 2'd3
    } err_t;

    localparam logic [7:0] SYM_ZERO = 8'h30;
    localparam logic [7:0] SYM_NINE = 8'h39;
    localparam logic [7:0] SYM_ADD  = 8'h2B;
    localparam logic [7:0] SYM_SUB  = 8'h2D;
    localparam logic [7:0] SYM_MUL  = 8'h2A;
    localparam logic [7:0] SYM_DIV  = 8'h2F;
    localparam logic [7:0] SYM_MOD  = 8'h25;

    localparam int DIV_BITS = 32;
    localparam int DCNT_W   = $clog2(DIV_BITS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP_B,
        ST_POP_A,
        ST_CAP_A,
        ST_EXEC,
        ST_DIV,
        ST_DIV_FIX,
        ST_PUSH,
        ST_FIN_POP,
        ST_FIN_CAP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic pop;
        logic cap_b;
        logic cap_a;
        logic exec;
        logic div_start;
        logic div_step;
        logic div_fix;
        logic push;
        logic cap_fin;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_is_op;
        logic div_go;
        logic last;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

// ===== hdl/pfx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/pfx_datapath.sv =====
// Datapath: operand stack (RAM), stack count, error latch, ALU, iterative divider, output register.
// Depends on pfx_pkg and pfx_ram.
module pfx_datapath #(
    parameter int STACK_DEPTH = 16,
    localparam int AW = $clog2(STACK_DEPTH),
    localparam int CW = $clog2(STACK_DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pfx_pkg::pfx_in_t  s_data,
    input  pfx_pkg::cmd_t     cmd,
    output pfx_pkg::stat_t    stat,
    output logic              m_valid,
    input  logic              m_ready,
    output pfx_pkg::pfx_out_t m_data
);
    import pfx_pkg::*;

    logic [CW-1:0]     count_reg, count_next;
    err_t              err_reg, err_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        sym_reg;
    logic              last_reg;
    logic [31:0]       opa_reg, opb_reg, res_reg;
    logic              empty_reg;
    logic [31:0]       rem_reg, quo_reg, dvs_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              an_reg, bn_reg;
    pfx_out_t          out_reg;

    logic [31:0] rd_data;
    logic [31:0] pop_val;
    logic        full, empty, is_div;
    logic [CW-1:0] count_dec;
    logic [7:0]  dig;
    logic        in_digit, in_is_op;
    logic [31:0] alu_res;
    logic [32:0] shifted, diff;
    logic        ge;
    logic        note_en;
    err_t        note_code;

    assign full      = (count_reg == CW'(STACK_DEPTH));
    assign empty     = (count_reg == '0);
    assign count_dec = count_reg - 1'b1;
    assign pop_val   = empty_reg ? 32'hFFFF_FFFF : rd_data;
    assign is_div    = (sym_reg == SYM_DIV) || (sym_reg == SYM_MOD);

    assign dig      = s_data.symbol - SYM_ZERO;
    assign in_digit = (s_data.symbol >= SYM_ZERO) && (s_data.symbol <= SYM_NINE);
    assign in_is_op = (s_data.symbol == SYM_ADD) || (s_data.symbol == SYM_SUB) ||
                      (s_data.symbol == SYM_MUL) || (s_data.symbol == SYM_DIV) ||
                      (s_data.symbol == SYM_MOD);

    pfx_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (aclk),
        .we    (cmd.push && !full),
        .waddr (count_reg[AW-1:0]),
        .wdata (res_reg),
        .re    (cmd.pop && !empty),
        .raddr (count_dec[AW-1:0]),
        .rdata (rd_data)
    );

    always_comb begin
        case (sym_reg)
            SYM_ADD: alu_res = opa_reg + opb_reg;
            SYM_SUB: alu_res = opa_reg - opb_reg;
            SYM_MUL: alu_res = opa_reg * opb_reg;
            default: alu_res = '0;
        endcase
    end

    // restoring divider, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_comb begin
        note_en      = 1'b0;
        note_code    = ERR_NONE;
        count_next   = count_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg;
        if (cmd.pop) begin
            if (empty) begin
                note_en   = 1'b1;
                note_code = ERR_UNDERFLOW;
            end else begin
                count_next = count_dec;
            end
        end
        if (cmd.exec && is_div) begin
            note_en   = 1'b1;
            note_code = ERR_DIVZERO;
        end
        if (cmd.push) begin
            if (full) begin
                note_en   = 1'b1;
                note_code = ERR_OVERFLOW;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end
        if (note_en && err_reg == ERR_NONE) begin
            err_next = note_code;
        end
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            count_next   = '0;
            err_next     = ERR_NONE;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            err_reg     <= ERR_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sym_reg  <= s_data.symbol;
            last_reg <= s_data.end_of_expression;
            res_reg  <= in_digit ? {24'd0, dig} : s_data.operand_value;
        end
        if (cmd.pop) begin
            empty_reg <= empty;
        end
        if (cmd.cap_b) begin
            opb_reg <= pop_val;
        end
        if (cmd.cap_a) begin
            opa_reg <= pop_val;
        end
        if (cmd.exec) begin
            res_reg <= alu_res;
        end
        if (cmd.div_start) begin
            an_reg   <= opa_reg[31];
            bn_reg   <= opb_reg[31];
            rem_reg  <= '0;
            quo_reg  <= opa_reg[31] ? (32'd0 - opa_reg) : opa_reg;
            dvs_reg  <= opb_reg[31] ? (32'd0 - opb_reg) : opb_reg;
            dcnt_reg <= DCNT_W'(DIV_BITS - 1);
        end
        if (cmd.div_step) begin
            rem_reg  <= ge ? diff[31:0] : shifted[31:0];
            quo_reg  <= {quo_reg[30:0], ge};
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.div_fix) begin
            if (sym_reg == SYM_MOD) begin
                res_reg <= an_reg ? (32'd0 - rem_reg) : rem_reg;
            end else begin
                res_reg <= (an_reg != bn_reg) ? (32'd0 - quo_reg) : quo_reg;
            end
        end
        if (cmd.cap_fin) begin
            res_reg <= pop_val;
        end
        if (cmd.emit) begin
            out_reg.result_value <= res_reg;
            out_reg.status       <= err_reg;
        end
    end

    assign stat.in_is_op = in_is_op;
    assign stat.div_go   = is_div && (opb_reg != '0);
    assign stat.last     = last_reg;
    assign stat.div_done = (dcnt_reg == '0);
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid_reg && count_reg == '0 && err_reg == ERR_NONE)
        else $error("expression end did not clear state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push && full |=> err_reg != ERR_NONE)
        else $error("push to full stack left no error");

endmodule

// ===== hdl/pfx_ctrl.sv =====
// Controller FSM: sequences pops, ALU/divider, push and final pop/emit per beat.
// Depends on pfx_pkg.
module pfx_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  pfx_pkg::stat_t stat,
    output pfx_pkg::cmd_t  cmd
);
    import pfx_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_is_op ? ST_POP_B : ST_PUSH;
                end
            end
            ST_POP_B: begin
                cmd.pop    = 1'b1;
                state_next = ST_POP_A;
            end
            ST_POP_A: begin
                cmd.cap_b  = 1'b1;
                cmd.pop    = 1'b1;
                state_next = ST_CAP_A;
            end
            ST_CAP_A: begin
                cmd.cap_a  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (stat.div_go) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = ST_PUSH;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_DIV_FIX;
                end
            end
            ST_DIV_FIX: begin
                cmd.div_fix = 1'b1;
                state_next  = ST_PUSH;
            end
            ST_PUSH: begin
                cmd.push   = 1'b1;
                state_next = stat.last ? ST_FIN_POP : ST_IDLE;
            end
            ST_FIN_POP: begin
                cmd.pop    = 1'b1;
                state_next = ST_FIN_CAP;
            end
            ST_FIN_CAP: begin
                cmd.cap_fin = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && !stat.out_free |=> state_reg == ST_EMIT)
        else $error("result emitted over an untaken beat");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !stat.in_is_op |=> state_reg == ST_PUSH)
        else $error("non-operator beat did not go straight to push");

endmodule

// ===== hdl/postfix_expression_evaluator_unit.sv =====
// Top level of the postfix (RPN) expression evaluator with a bounded operand stack.
// Depends on pfx_pkg, pfx_ctrl, pfx_datapath (which holds pfx_ram).
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_valid / s_ready  | s_data : pfx_in_t  (symbol, operand_value, end_of_expression)
//   m_      | out | m_valid / m_ready  | m_data : pfx_out_t (result_value, status)
//
// Digit or plain value: load, then push. Operator + - *, or / % by zero: load, pop B,
// pop A, capture A, execute, push. Operator / % by nonzero: the 32-step restoring divider
// and a sign fix replace execute. Last beat: final pop and emit via the output register.
// Stack RAM is not cleared after reset; the block accepts beats right out of reset.
// The emit step stalls while the output register still holds an untaken beat.
module postfix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pfx_pkg::pfx_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pfx_pkg::pfx_out_t m_data
);
    import pfx_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    pfx_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pfx_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
